@@ sv/pcmfo_pkg.sv @@
// pcmfo_pkg: shared types and constants for the pcm linear fade-out block
// no dependencies; used by pcmfo_lane, pcmfo_merge and pcm_linear_fade_out
package pcmfo_pkg;

  localparam int SAMPLE_W = 16;                      // sample width
  localparam int COUNT_W  = 32;                      // body and fade register width
  localparam int POS_W    = 34;                      // frame position width
  localparam int PROD_W   = SAMPLE_W + COUNT_W;      // |sample| * remaining
  localparam int QUO_W    = SAMPLE_W;                // quotient bits per division
  localparam int STEP_CW  = $clog2(QUO_W);           // division step counter width
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_FRAMES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_FRAMES    = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } pcmfo_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       fading;
    logic                       finished;
  } pcmfo_out_t;

  // result of one lane: quotient magnitude and sign of the sample
  typedef struct packed {
    logic             neg;
    logic [QUO_W-1:0] quo;
  } lane_res_t;

  // frame region found by the position classifier
  typedef struct packed {
    logic fading;
    logic finished;
  } region_t;

endpackage

@@ sv/pcmfo_lane.sv @@
// pcmfo_lane: one channel's scaling core, multiply then restoring division
// depends on pcmfo_pkg
module pcmfo_lane
  import pcmfo_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [COUNT_W-1:0]         remaining,
  input  logic [COUNT_W-1:0]         divisor,
  output logic                       done,
  output lane_res_t                  res
);

  typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV} lstate_t;

  lstate_t                    state_r, state_nxt;
  logic signed [SAMPLE_W-1:0] smp_r, smp_nxt;
  logic [COUNT_W-1:0]         rem_in_r, rem_in_nxt;
  logic [COUNT_W-1:0]         div_r, div_nxt;
  logic [COUNT_W-1:0]         part_r, part_nxt;
  logic [SAMPLE_W-1:0]        low_r, low_nxt;
  logic [QUO_W-1:0]           quo_r, quo_nxt;
  logic                       neg_r, neg_nxt;
  logic [STEP_CW-1:0]         cnt_r, cnt_nxt;
  logic                       done_r, done_nxt;

  logic [SAMPLE_W-1:0] mag;
  logic [PROD_W-1:0]   prod;
  logic [COUNT_W+1:0]  trial;
  logic                fits;

  assign mag   = smp_r[SAMPLE_W-1] ? SAMPLE_W'(-smp_r) : SAMPLE_W'(smp_r);
  assign prod  = PROD_W'(mag) * PROD_W'(rem_in_r);
  assign trial = {1'b0, part_r, low_r[SAMPLE_W-1]} - {2'b0, div_r};
  assign fits  = !trial[COUNT_W+1];

  always_comb begin
    state_nxt  = state_r;
    smp_nxt    = smp_r;
    rem_in_nxt = rem_in_r;
    div_nxt    = div_r;
    part_nxt   = part_r;
    low_nxt    = low_r;
    quo_nxt    = quo_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    unique case (state_r)
      L_IDLE: begin
        if (start) begin
          smp_nxt    = sample;
          rem_in_nxt = remaining;
          div_nxt    = divisor;
          state_nxt  = L_MUL;
        end
      end
      L_MUL: begin
        // high part is below the divisor since the quotient fits QUO_W bits
        part_nxt  = prod[PROD_W-1:SAMPLE_W];
        low_nxt   = prod[SAMPLE_W-1:0];
        neg_nxt   = smp_r[SAMPLE_W-1];
        quo_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = L_DIV;
      end
      L_DIV: begin
        part_nxt = fits ? trial[COUNT_W-1:0] : {part_r[COUNT_W-2:0], low_r[SAMPLE_W-1]};
        low_nxt  = {low_r[SAMPLE_W-2:0], 1'b0};
        quo_nxt  = {quo_r[QUO_W-2:0], fits};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == STEP_CW'(QUO_W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = L_IDLE;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    smp_r    <= smp_nxt;
    rem_in_r <= rem_in_nxt;
    div_r    <= div_nxt;
    part_r   <= part_nxt;
    low_r    <= low_nxt;
    quo_r    <= quo_nxt;
    neg_r    <= neg_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign done    = done_r;
  assign res.neg = neg_r;
  assign res.quo = quo_r;

endmodule

@@ sv/pcmfo_merge.sv @@
// pcmfo_merge: combines both lane results with the frame region into one frame
// depends on pcmfo_pkg
module pcmfo_merge
  import pcmfo_pkg::*;
(
  input  region_t    region,
  input  pcmfo_in_t  pass,
  input  lane_res_t  lres,
  input  lane_res_t  rres,
  output pcmfo_out_t result
);

  function automatic logic signed [SAMPLE_W-1:0] restore(input lane_res_t r);
    logic signed [SAMPLE_W:0] v;
    v = r.neg ? -$signed({1'b0, r.quo}) : $signed({1'b0, r.quo});
    if (v > $signed((SAMPLE_W+1)'(2**(SAMPLE_W-1) - 1)))
      restore = {1'b0, {(SAMPLE_W-1){1'b1}}};
    else if (v < -$signed((SAMPLE_W+1)'(2**(SAMPLE_W-1))))
      restore = {1'b1, {(SAMPLE_W-1){1'b0}}};
    else
      restore = v[SAMPLE_W-1:0];
  endfunction

  always_comb begin
    result.fading   = region.fading;
    result.finished = region.finished;
    if (region.fading) begin
      result.left_out  = restore(lres);
      result.right_out = restore(rres);
    end else if (region.finished) begin
      result.left_out  = '0;
      result.right_out = '0;
    end else begin
      result.left_out  = pass.left_in;
      result.right_out = pass.right_in;
    end
  end

endmodule

@@ sv/pcm_linear_fade_out.sv @@
// pcm_linear_fade_out: top level of the stereo linear fade-out envelope
// depends on pcmfo_pkg, pcmfo_lane and pcmfo_merge
//
// One stereo frame per request. A saturating 34-bit frame position decides the
// treatment: frames before body_frames pass, the next fade_frames frames are
// scaled by remaining/fade_frames (truncated toward zero), later frames are
// silent with finished set; length_enabled clear passes everything. The
// position compare happens in the accepting cycle. Each frame then passes
// from acceptance to the output register through a region compare, the
// multiply and 16 restoring division steps in the two channel lanes, which
// run side by side, a check that the lanes have finished and a merge that
// waits while the output register is full and stalled. A new frame is taken
// as soon as the previous one sits in the output register, even if it has
// not been taken yet. Configuration writes are always ready and must only
// be made while no frame is in flight.
module pcm_linear_fade_out
  import pcmfo_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input frames
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pcmfo_in_t            in_data,
  // result frames
  output logic                 out_valid,
  input  logic                 out_stall,
  output pcmfo_out_t           out_data,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_data
);

  typedef enum logic [1:0] {T_IDLE, T_CLASS, T_RUN, T_PUSH} tstate_t;

  // configuration registers
  logic               len_en_r;
  logic [COUNT_W-1:0] body_r;
  logic [COUNT_W-1:0] fade_r;

  // control state and registered outputs
  tstate_t            state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  pcmfo_out_t         out_data_r, out_data_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;

  // frame under work
  pcmfo_in_t          smp_r, smp_nxt;
  logic [POS_W-1:0]   into_r, into_nxt;
  logic               past_body_r, past_body_nxt;
  logic               en_r, en_nxt;
  region_t            region_r, region_nxt;

  logic               accept;
  logic [POS_W:0]     body_diff;
  logic [POS_W:0]     fade_diff;
  logic               in_fade;
  logic               lane_start;
  logic               l_done, r_done;
  lane_res_t          lres, rres;
  pcmfo_out_t         merged;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_en_r <= 1'b0;
      body_r   <= '0;
      fade_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LENGTH_ENABLED: len_en_r <= cfg_data[0];
        CFG_BODY_FRAMES:    body_r   <= cfg_data;
        CFG_FADE_FRAMES:    fade_r   <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != T_IDLE);

  // position minus body, borrow bit says position is still in the body
  assign body_diff = {1'b0, pos_r} - {3'b0, body_r};
  // fade minus frames into the fade, positive means still fading
  assign fade_diff = {3'b0, fade_r} - {1'b0, into_r};
  assign in_fade   = !fade_diff[POS_W] && (fade_diff != '0);

  assign lane_start = (state_r == T_CLASS);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pos_nxt       = pos_r;
    smp_nxt       = smp_r;
    into_nxt      = into_r;
    past_body_nxt = past_body_r;
    en_nxt        = en_r;
    region_nxt    = region_r;

    // output register drains independently of the core
    if (out_valid_r && !out_stall)
      out_valid_nxt = 1'b0;

    unique case (state_r)
      T_IDLE: begin
        if (accept) begin
          smp_nxt       = in_data;
          into_nxt      = body_diff[POS_W-1:0];
          past_body_nxt = !body_diff[POS_W];
          en_nxt        = len_en_r;
          pos_nxt       = (&pos_r) ? pos_r : pos_r + 1'b1;  // saturating count
          state_nxt     = T_CLASS;
        end
      end
      T_CLASS: begin
        region_nxt.fading   = en_r && past_body_r && in_fade;
        region_nxt.finished = en_r && past_body_r && !in_fade;
        state_nxt           = T_RUN;
      end
      T_RUN: begin
        if (l_done)
          state_nxt = T_PUSH;
      end
      T_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = merged;
          state_nxt     = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
    out_data_r  <= out_data_nxt;
    smp_r       <= smp_nxt;
    into_r      <= into_nxt;
    past_body_r <= past_body_nxt;
    en_r        <= en_nxt;
    region_r    <= region_nxt;
  end

  // the lanes take remaining straight from the region compare
  pcmfo_lane u_lane_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (lane_start),
    .sample    (smp_r.left_in),
    .remaining (fade_diff[COUNT_W-1:0]),
    .divisor   (fade_r),
    .done      (l_done),
    .res       (lres)
  );

  pcmfo_lane u_lane_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (lane_start),
    .sample    (smp_r.right_in),
    .remaining (fade_diff[COUNT_W-1:0]),
    .divisor   (fade_r),
    .done      (r_done),
    .res       (rres)
  );

  pcmfo_merge u_merge (
    .region (region_r),
    .pass   (smp_r),
    .lres   (lres),
    .rres   (rres),
    .result (merged)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // both lanes run in lock step
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    l_done == r_done)
    else $error("lane done pulses out of step");

  // an accepted request moves the core to classification
  a_accept_class: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == T_CLASS))
    else $error("accepted request not classified");

  // a frame is never both fading and finished
  a_region_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.fading && out_data.finished))
    else $error("fading and finished both set");

  // frame position moves only on acceptance
  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(pos_r))
    else $error("frame position changed without a request");
`endif

endmodule
